FILE: rtl/sdbr_pkg.sv
// ----------------------------------------------------------------------------
// sdbr_pkg: shared types and constants of the sd spi-mode block reader
// phase codes, operation codes, status codes, command numbers and the
// command byte formatter
// ----------------------------------------------------------------------------
`default_nettype none

package sdbr_pkg;

	// fixed sector size of the card
	localparam int unsigned BLOCK_BYTES = 512;
	localparam int unsigned IDX_W       = 10;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CLOCKS,
		PH_SEND,
		PH_POLL,
		PH_TOKEN,
		PH_DATA,
		PH_CRC
	} phase_t;

	// input operations
	localparam logic [1:0] OP_INIT = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_BYTE = 2'd2;
	localparam logic [1:0] OP_TICK = 2'd3;

	// completion status
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_IDLE    = 3'd1;
	localparam logic [2:0] ST_NOT_READY  = 3'd2;
	localparam logic [2:0] ST_READ_FAIL  = 3'd3;
	localparam logic [2:0] ST_NO_TOKEN   = 3'd4;

	// card commands
	localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
	localparam logic [5:0] CMD_IF_COND  = 6'd8;
	localparam logic [5:0] CMD_READ     = 6'd17;
	localparam logic [5:0] CMD_SEND_OP  = 6'd41;
	localparam logic [5:0] CMD_APP      = 6'd55;

	// bus constants
	localparam logic [7:0] CMD_PREFIX   = 8'h40;
	localparam logic [7:0] CRC_GO_IDLE  = 8'h95;
	localparam logic [7:0] CRC_IF_COND  = 8'h87;
	localparam logic [7:0] FILL_BYTE    = 8'hFF;
	localparam logic [7:0] DATA_TOKEN   = 8'hFE;
	localparam logic [7:0] R1_IDLE      = 8'h01;
	localparam logic [7:0] R1_READY     = 8'h00;
	localparam logic [2:0] CMD_LEN      = 3'd6;

	// configuration register indexes
	localparam logic REG_INIT_TIMEOUT = 1'b0;
	localparam logic REG_READ_TIMEOUT = 1'b1;

	// one result beat
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       chip_select_n;
		logic       fast_clock;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       last;
		logic       done_res;
		logic [2:0] status;
		logic       busy_res;
	} result_t;

	// byte idx of a six-byte command frame: prefix, argument msb first, crc
	function automatic logic [7:0] cmd_byte(input logic [2:0] idx, input logic [5:0] cmd,
			input logic [31:0] arg);
		logic [7:0] b;
		case (idx)
			3'd0: b = CMD_PREFIX | {2'b00, cmd};
			3'd1: b = arg[31:24];
			3'd2: b = arg[23:16];
			3'd3: b = arg[15:8];
			3'd4: b = arg[7:0];
			default: begin
				if (cmd == CMD_GO_IDLE)
					b = CRC_GO_IDLE;
				else if (cmd == CMD_IF_COND)
					b = CRC_IF_COND;
				else
					b = FILL_BYTE;
			end
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sd_spi_mode_block_reader.sv
// ----------------------------------------------------------------------------
// sd_spi_mode_block_reader: host-side sd card spi-mode init and block read
// drives a byte-wide spi master one beat at a time, runs the card init
// sequence and reads single 512-byte sectors
// ----------------------------------------------------------------------------
// Every input beat (start init, start read, received spi byte or timer tick)
// produces exactly one result beat. The block takes one input beat per clock:
// the state update and the result are computed in the same cycle and land in
// a single result register, so the result shows in the next cycle and the
// sustained rate is one beat per clock as long as out_ready is high. When the
// result register is full and out_ready is low, in_ready drops until it is
// taken. Configuration (cfg_write, cfg_index, cfg_data) is applied at once;
// index 0 is the init timeout in ticks, index 1 the read timeout in ticks.
`default_nettype none

module sd_spi_mode_block_reader #(
	parameter int unsigned IDLE_BYTES     = 10,
	parameter int unsigned RESPONSE_POLLS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// configuration writes
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,

	// input beats
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [22:0] sector,
	input  wire logic [7:0]  rx_byte,

	// result beats
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             tx_valid,
	output logic [7:0]       tx_byte,
	output logic             chip_select_n,
	output logic             fast_clock,
	output logic             data_valid,
	output logic [7:0]       data_byte,
	output logic             last,
	output logic             done_res,
	output logic [2:0]       status,
	output logic             busy_res
);

	localparam int unsigned POLL_W = $clog2(RESPONSE_POLLS);
	localparam int unsigned IDX_W  = sdbr_pkg::IDX_W;

	localparam logic [POLL_W-1:0] POLL_LAST = POLL_W'(RESPONSE_POLLS - 1);
	localparam logic [IDX_W-1:0]  IDLE_CNT  = IDX_W'(IDLE_BYTES);
	localparam logic [IDX_W-1:0]  BLK_CNT   = IDX_W'(sdbr_pkg::BLOCK_BYTES);

	// configuration registers
	logic [15:0] init_limit_q;
	logic [15:0] read_limit_q;

	// control state
	sdbr_pkg::phase_t   phase_q, phase_n;
	logic [IDX_W-1:0]   idx_q, idx_n;
	logic [POLL_W-1:0]  poll_q, poll_n;
	logic [5:0]         cmd_q, cmd_n;
	logic [31:0]        arg_q, arg_n;
	logic [15:0]        ticks_q, ticks_n;
	logic               fast_q, fast_n;
	logic               csn_q, csn_n;

	// result register
	sdbr_pkg::result_t  res_q, res_n;
	logic               out_valid_q;

	logic               accept;
	logic               busy;
	logic [IDX_W-1:0]   idx_inc;
	logic [2:0]         send_idx;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign busy     = (phase_q != sdbr_pkg::PH_IDLE);
	assign idx_inc  = idx_q + IDX_W'(1);
	assign send_idx = idx_q[2:0] + 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_limit_q <= 16'd2000;
			read_limit_q <= 16'd300;
		end else if (cfg_write) begin
			if (cfg_index == sdbr_pkg::REG_INIT_TIMEOUT)
				init_limit_q <= cfg_data;
			else
				read_limit_q <= cfg_data;
		end
	end

	// next state and result of one beat
	always_comb begin
		phase_n = phase_q;
		idx_n   = idx_q;
		poll_n  = poll_q;
		cmd_n   = cmd_q;
		arg_n   = arg_q;
		ticks_n = ticks_q;
		fast_n  = fast_q;
		csn_n   = csn_q;
		res_n   = '0;

		case (operation)
			sdbr_pkg::OP_INIT: begin
				if (!busy) begin
					fast_n  = 1'b0;
					csn_n   = 1'b1;
					phase_n = sdbr_pkg::PH_CLOCKS;
					idx_n   = '0;
					poll_n  = '0;
					ticks_n = '0;
					res_n.tx_valid = 1'b1;
					res_n.tx_byte  = sdbr_pkg::FILL_BYTE;
				end
			end
			sdbr_pkg::OP_READ: begin
				if (!busy) begin
					csn_n   = 1'b0;
					ticks_n = '0;
					cmd_n   = sdbr_pkg::CMD_READ;
					arg_n   = {sector, 9'd0};
					phase_n = sdbr_pkg::PH_SEND;
					idx_n   = '0;
					poll_n  = '0;
					res_n.tx_valid = 1'b1;
					res_n.tx_byte  = sdbr_pkg::cmd_byte(3'd0, sdbr_pkg::CMD_READ,
						{sector, 9'd0});
				end
			end
			sdbr_pkg::OP_BYTE: begin
				if (busy) begin
					res_n.tx_valid = 1'b1;
					res_n.tx_byte  = sdbr_pkg::FILL_BYTE;
					case (phase_q)
						sdbr_pkg::PH_CLOCKS: begin
							idx_n = idx_inc;
							if (idx_inc >= IDLE_CNT) begin
								// idle clocks done, select and go to idle state
								csn_n   = 1'b0;
								ticks_n = '0;
								cmd_n   = sdbr_pkg::CMD_GO_IDLE;
								arg_n   = '0;
								phase_n = sdbr_pkg::PH_SEND;
								idx_n   = '0;
								poll_n  = '0;
								res_n.tx_byte = sdbr_pkg::cmd_byte(3'd0,
									sdbr_pkg::CMD_GO_IDLE, 32'd0);
							end
						end
						sdbr_pkg::PH_SEND: begin
							if (send_idx < sdbr_pkg::CMD_LEN) begin
								idx_n = idx_inc;
								res_n.tx_byte = sdbr_pkg::cmd_byte(send_idx, cmd_q, arg_q);
							end else begin
								phase_n = sdbr_pkg::PH_POLL;
								idx_n   = '0;
								poll_n  = '0;
							end
						end
						sdbr_pkg::PH_POLL: begin
							if (!rx_byte[7] || poll_q == POLL_LAST) begin
								poll_n = '0;
								// response byte in hand
								if (cmd_q == sdbr_pkg::CMD_GO_IDLE) begin
									if (rx_byte == sdbr_pkg::R1_IDLE) begin
										ticks_n = '0;
										cmd_n   = sdbr_pkg::CMD_APP;
									end else if (ticks_q > init_limit_q) begin
										cmd_n = cmd_q;
									end else begin
										cmd_n = sdbr_pkg::CMD_GO_IDLE;
									end
									if (rx_byte != sdbr_pkg::R1_IDLE && ticks_q > init_limit_q) begin
										phase_n = sdbr_pkg::PH_IDLE;
										idx_n   = '0;
										csn_n   = 1'b1;
										fast_n  = 1'b1;
										res_n.tx_valid = 1'b0;
										res_n.tx_byte  = '0;
										res_n.done_res = 1'b1;
										res_n.status   = sdbr_pkg::ST_NO_IDLE;
									end else begin
										arg_n   = '0;
										phase_n = sdbr_pkg::PH_SEND;
										idx_n   = '0;
										res_n.tx_byte = sdbr_pkg::cmd_byte(3'd0, cmd_n, 32'd0);
									end
								end else if (cmd_q == sdbr_pkg::CMD_APP) begin
									// app command response is not checked
									cmd_n   = sdbr_pkg::CMD_SEND_OP;
									arg_n   = '0;
									phase_n = sdbr_pkg::PH_SEND;
									idx_n   = '0;
									res_n.tx_byte = sdbr_pkg::cmd_byte(3'd0,
										sdbr_pkg::CMD_SEND_OP, 32'd0);
								end else if (cmd_q == sdbr_pkg::CMD_SEND_OP) begin
									if (rx_byte == sdbr_pkg::R1_READY || ticks_q > init_limit_q) begin
										phase_n = sdbr_pkg::PH_IDLE;
										idx_n   = '0;
										csn_n   = 1'b1;
										fast_n  = 1'b1;
										res_n.tx_valid = 1'b0;
										res_n.tx_byte  = '0;
										res_n.done_res = 1'b1;
										res_n.status   = (rx_byte == sdbr_pkg::R1_READY) ?
											sdbr_pkg::ST_OK : sdbr_pkg::ST_NOT_READY;
									end else begin
										cmd_n   = sdbr_pkg::CMD_APP;
										arg_n   = '0;
										phase_n = sdbr_pkg::PH_SEND;
										idx_n   = '0;
										res_n.tx_byte = sdbr_pkg::cmd_byte(3'd0,
											sdbr_pkg::CMD_APP, 32'd0);
									end
								end else begin
									// block read command
									if (rx_byte == sdbr_pkg::R1_READY) begin
										phase_n = sdbr_pkg::PH_TOKEN;
										ticks_n = '0;
									end else if (ticks_q > read_limit_q) begin
										phase_n = sdbr_pkg::PH_IDLE;
										idx_n   = '0;
										csn_n   = 1'b1;
										res_n.tx_valid = 1'b0;
										res_n.tx_byte  = '0;
										res_n.done_res = 1'b1;
										res_n.status   = sdbr_pkg::ST_READ_FAIL;
									end else begin
										cmd_n   = sdbr_pkg::CMD_READ;
										phase_n = sdbr_pkg::PH_SEND;
										idx_n   = '0;
										res_n.tx_byte = sdbr_pkg::cmd_byte(3'd0,
											sdbr_pkg::CMD_READ, arg_q);
									end
								end
							end else begin
								poll_n = poll_q + POLL_W'(1);
							end
						end
						sdbr_pkg::PH_TOKEN: begin
							if (rx_byte == sdbr_pkg::DATA_TOKEN) begin
								phase_n = sdbr_pkg::PH_DATA;
								idx_n   = '0;
							end else if (rx_byte != sdbr_pkg::FILL_BYTE ||
									ticks_q > read_limit_q) begin
								phase_n = sdbr_pkg::PH_IDLE;
								idx_n   = '0;
								poll_n  = '0;
								csn_n   = 1'b1;
								res_n.tx_valid = 1'b0;
								res_n.tx_byte  = '0;
								res_n.done_res = 1'b1;
								res_n.status   = sdbr_pkg::ST_NO_TOKEN;
							end
						end
						sdbr_pkg::PH_DATA: begin
							res_n.data_valid = 1'b1;
							res_n.data_byte  = rx_byte;
							idx_n = idx_inc;
							if (idx_inc >= BLK_CNT) begin
								res_n.last = 1'b1;
								phase_n    = sdbr_pkg::PH_CRC;
								idx_n      = '0;
							end
						end
						sdbr_pkg::PH_CRC: begin
							idx_n = idx_inc;
							if (idx_inc >= IDX_W'(2)) begin
								phase_n = sdbr_pkg::PH_IDLE;
								idx_n   = '0;
								poll_n  = '0;
								csn_n   = 1'b1;
								res_n.tx_valid = 1'b0;
								res_n.tx_byte  = '0;
								res_n.done_res = 1'b1;
								res_n.status   = sdbr_pkg::ST_OK;
							end
						end
						default: begin
							res_n.tx_valid = 1'b0;
							res_n.tx_byte  = '0;
						end
					endcase
				end
			end
			default: begin
				// tick: saturating timeout counter
				if (busy && ticks_q != 16'hFFFF)
					ticks_n = ticks_q + 16'd1;
			end
		endcase

		res_n.chip_select_n = csn_n;
		res_n.fast_clock    = fast_n;
		res_n.busy_res      = (phase_n != sdbr_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sdbr_pkg::PH_IDLE;
			idx_q       <= '0;
			poll_q      <= '0;
			cmd_q       <= '0;
			arg_q       <= '0;
			ticks_q     <= '0;
			fast_q      <= 1'b0;
			csn_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_n;
				idx_q       <= idx_n;
				poll_q      <= poll_n;
				cmd_q       <= cmd_n;
				arg_q       <= arg_n;
				ticks_q     <= ticks_n;
				fast_q      <= fast_n;
				csn_q       <= csn_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res_n;
	end

	assign out_valid     = out_valid_q;
	assign tx_valid      = res_q.tx_valid;
	assign tx_byte       = res_q.tx_byte;
	assign chip_select_n = res_q.chip_select_n;
	assign fast_clock    = res_q.fast_clock;
	assign data_valid    = res_q.data_valid;
	assign data_byte     = res_q.data_byte;
	assign last          = res_q.last;
	assign done_res      = res_q.done_res;
	assign status        = res_q.status;
	assign busy_res      = res_q.busy_res;

endmodule

`default_nettype wire
